// ----- hdl/ddoc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoc_pkg
// Shared types, constants and the operation table of the odometry and
// covariance block.
// ----------------------------------------------------------------------------
package ddoc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_X          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MM_PER_PULSE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_WHEEL_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_VARIANCE = 3'd5;

  localparam logic [31:0] RST_MM_PER_PULSE     = 32'd1341375;
  localparam logic [31:0] RST_INV_WHEEL_BASE   = 32'd24826400;
  localparam logic [31:0] RST_ENCODER_VARIANCE = 32'd42949673;

  localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic [63:0]        BAM_PER_RAD_Q4 = 64'd10937044409;

  localparam logic [62:0] LIM_BIG_VAL = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0] LIM_COV_VAL = 63'h0000_7FFF_FFFF_FFFF;
  localparam logic [62:0] LIM_POS_VAL = 63'h0000_0100_0000_0000;

  localparam int unsigned PC_W = 6;
  localparam logic [PC_W-1:0] OP_PRE_CORDIC = 6'd3;
  localparam logic [PC_W-1:0] OP_LAST       = 6'd37;

  typedef struct packed {
    logic signed [31:0] count_right;
    logic signed [31:0] count_left;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        pose_heading;
    logic signed [47:0] var_xx;
    logic signed [47:0] var_xy;
    logic signed [47:0] var_xa;
    logic signed [47:0] var_yy;
    logic signed [47:0] var_ya;
    logic signed [47:0] var_aa;
  } out_item_t;

  typedef enum logic [1:0] {MODE_MULSH, MODE_FLOOR, MODE_RAW} mul_mode_t;
  typedef enum logic [1:0] {LIM_BIG, LIM_COV, LIM_POS} lim_t;
  typedef enum logic [1:0] {SCL_ONE, SCL_TWO, SCL_NEG} scale_t;

  typedef enum logic [4:0] {
    SRC_DR, SRC_DL, SRC_MPP, SRC_W, SRC_IWB, SRC_RADQ, SRC_KBAM, SRC_DD,
    SRC_C, SRC_S, SRC_A, SRC_B, SRC_HS, SRC_HC, SRC_VAR, SRC_Q2T, SRC_Q1,
    SRC_Q2, SRC_CC, SRC_SS, SRC_CSP, SRC_HS2, SRC_HC2, SRC_HSC, SRC_AA,
    SRC_AB, SRC_BB, SRC_PXA, SRC_PYA, SRC_PAA
  } src_t;

  typedef enum logic [4:0] {
    DST_TR, DST_TL, DST_RADQ, DST_PROD, DST_DX, DST_DY, DST_A, DST_B,
    DST_HS, DST_HC, DST_Q2T, DST_Q2, DST_CC, DST_SS, DST_CSP, DST_HS2,
    DST_HC2, DST_HSC, DST_AA, DST_AB, DST_BB, DST_ACC0, DST_ACC1,
    DST_ACC2, DST_ACC3, DST_ACC4
  } dest_t;

  typedef struct packed {
    mul_mode_t   mode;
    src_t        src_a;
    src_t        src_b;
    logic [5:0]  sh;
    lim_t        lim;
    dest_t       dest;
    scale_t      scale;
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRIME, ST_INIT, ST_MUL_GO, ST_MUL_WAIT, ST_CORD_GO,
    ST_CORD_RUN, ST_COMMIT, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {MS_IDLE, MS_MUL, MS_SHF, MS_SAT} mul_state_t;

  typedef struct packed {
    logic            load_in;
    logic            prime;
    logic            init_acc;
    logic            mul_start;
    logic            cord_start;
    logic            commit;
    logic            emit;
    logic [PC_W-1:0] pc;
  } ctrl_cmd_t;

  typedef struct packed {
    logic primed;
    logic mul_done;
    logic cord_done;
    logic out_free;
  } ctrl_sts_t;

  // Operation sequence: travels, heading change, then (after CORDIC) the
  // pose deltas, Jacobian terms and covariance accumulation.
  function automatic op_t op_info(input logic [PC_W-1:0] pc);
    op_t o;
    unique case (pc)
      6'd0:  o = '{MODE_FLOOR, SRC_DR,   SRC_MPP,  6'd8,  LIM_BIG, DST_TR,   SCL_ONE};
      6'd1:  o = '{MODE_FLOOR, SRC_DL,   SRC_MPP,  6'd8,  LIM_BIG, DST_TL,   SCL_ONE};
      6'd2:  o = '{MODE_MULSH, SRC_W,    SRC_IWB,  6'd32, LIM_BIG, DST_RADQ, SCL_ONE};
      6'd3:  o = '{MODE_RAW,   SRC_RADQ, SRC_KBAM, 6'd0,  LIM_BIG, DST_PROD, SCL_ONE};
      6'd4:  o = '{MODE_MULSH, SRC_DD,   SRC_C,    6'd38, LIM_POS, DST_DX,   SCL_ONE};
      6'd5:  o = '{MODE_MULSH, SRC_DD,   SRC_S,    6'd38, LIM_POS, DST_DY,   SCL_ONE};
      6'd6:  o = '{MODE_MULSH, SRC_DD,   SRC_S,    6'd30, LIM_BIG, DST_A,    SCL_NEG};
      6'd7:  o = '{MODE_MULSH, SRC_DD,   SRC_C,    6'd30, LIM_BIG, DST_B,    SCL_ONE};
      6'd8:  o = '{MODE_MULSH, SRC_DD,   SRC_S,    6'd31, LIM_BIG, DST_HS,   SCL_ONE};
      6'd9:  o = '{MODE_MULSH, SRC_DD,   SRC_C,    6'd31, LIM_BIG, DST_HC,   SCL_ONE};
      6'd10: o = '{MODE_MULSH, SRC_VAR,  SRC_IWB,  6'd32, LIM_BIG, DST_Q2T,  SCL_ONE};
      6'd11: o = '{MODE_MULSH, SRC_Q2T,  SRC_IWB,  6'd39, LIM_BIG, DST_Q2,   SCL_ONE};
      6'd12: o = '{MODE_MULSH, SRC_C,    SRC_C,    6'd30, LIM_BIG, DST_CC,   SCL_ONE};
      6'd13: o = '{MODE_MULSH, SRC_S,    SRC_S,    6'd30, LIM_BIG, DST_SS,   SCL_ONE};
      6'd14: o = '{MODE_MULSH, SRC_C,    SRC_S,    6'd30, LIM_BIG, DST_CSP,  SCL_ONE};
      6'd15: o = '{MODE_MULSH, SRC_HS,   SRC_HS,   6'd24, LIM_BIG, DST_HS2,  SCL_ONE};
      6'd16: o = '{MODE_MULSH, SRC_HC,   SRC_HC,   6'd24, LIM_BIG, DST_HC2,  SCL_ONE};
      6'd17: o = '{MODE_MULSH, SRC_HS,   SRC_HC,   6'd24, LIM_BIG, DST_HSC,  SCL_ONE};
      6'd18: o = '{MODE_MULSH, SRC_A,    SRC_A,    6'd24, LIM_BIG, DST_AA,   SCL_ONE};
      6'd19: o = '{MODE_MULSH, SRC_A,    SRC_B,    6'd24, LIM_BIG, DST_AB,   SCL_ONE};
      6'd20: o = '{MODE_MULSH, SRC_B,    SRC_B,    6'd24, LIM_BIG, DST_BB,   SCL_ONE};
      6'd21: o = '{MODE_MULSH, SRC_A,    SRC_PXA,  6'd24, LIM_COV, DST_ACC0, SCL_TWO};
      6'd22: o = '{MODE_MULSH, SRC_AA,   SRC_PAA,  6'd24, LIM_COV, DST_ACC0, SCL_ONE};
      6'd23: o = '{MODE_MULSH, SRC_Q1,   SRC_CC,   6'd30, LIM_COV, DST_ACC0, SCL_ONE};
      6'd24: o = '{MODE_MULSH, SRC_Q2,   SRC_HS2,  6'd24, LIM_COV, DST_ACC0, SCL_ONE};
      6'd25: o = '{MODE_MULSH, SRC_A,    SRC_PYA,  6'd24, LIM_COV, DST_ACC1, SCL_ONE};
      6'd26: o = '{MODE_MULSH, SRC_B,    SRC_PXA,  6'd24, LIM_COV, DST_ACC1, SCL_ONE};
      6'd27: o = '{MODE_MULSH, SRC_AB,   SRC_PAA,  6'd24, LIM_COV, DST_ACC1, SCL_ONE};
      6'd28: o = '{MODE_MULSH, SRC_Q1,   SRC_CSP,  6'd30, LIM_COV, DST_ACC1, SCL_ONE};
      6'd29: o = '{MODE_MULSH, SRC_Q2,   SRC_HSC,  6'd24, LIM_COV, DST_ACC1, SCL_NEG};
      6'd30: o = '{MODE_MULSH, SRC_A,    SRC_PAA,  6'd24, LIM_COV, DST_ACC2, SCL_ONE};
      6'd31: o = '{MODE_MULSH, SRC_Q2,   SRC_HS,   6'd24, LIM_COV, DST_ACC2, SCL_NEG};
      6'd32: o = '{MODE_MULSH, SRC_B,    SRC_PYA,  6'd24, LIM_COV, DST_ACC3, SCL_TWO};
      6'd33: o = '{MODE_MULSH, SRC_BB,   SRC_PAA,  6'd24, LIM_COV, DST_ACC3, SCL_ONE};
      6'd34: o = '{MODE_MULSH, SRC_Q1,   SRC_SS,   6'd30, LIM_COV, DST_ACC3, SCL_ONE};
      6'd35: o = '{MODE_MULSH, SRC_Q2,   SRC_HC2,  6'd24, LIM_COV, DST_ACC3, SCL_ONE};
      6'd36: o = '{MODE_MULSH, SRC_B,    SRC_PAA,  6'd24, LIM_COV, DST_ACC4, SCL_ONE};
      6'd37: o = '{MODE_MULSH, SRC_Q2,   SRC_HC,   6'd24, LIM_COV, DST_ACC4, SCL_ONE};
      default: o = '{MODE_MULSH, SRC_DR, SRC_MPP, 6'd0, LIM_BIG, DST_TR, SCL_ONE};
    endcase
    return o;
  endfunction

  // atan(2^-i) as binary angle, 2^32 per turn
  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/ddoc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoc_mul
// Sequential signed 64x64 multiplier: four 32x32 partial products, then
// shift with truncation toward zero (or floor) and, outside raw mode, magnitude saturation.
// ----------------------------------------------------------------------------
module ddoc_mul
  import ddoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  mul_mode_t   mode,
  input  logic [5:0]  sh,
  input  logic [62:0] lim,
  output logic        done,
  output logic [63:0] res
);

  mul_state_t   state_r, state_nxt;
  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  mul_mode_t    mode_r;
  logic [5:0]   sh_r;
  logic [62:0]  lim_r;
  logic [2:0]   cnt_r;
  logic [63:0]  pp_r;
  logic [1:0]   ppw_r;
  logic         pp_v_r;
  logic [127:0] acc_r;
  logic [127:0] q_r;
  logic         done_r;
  logic [63:0]  res_r;

  logic         ld, run, shf, fin;
  logic [31:0]  ha, hb;
  logic [63:0]  pp_full;
  logic [127:0] bias;
  logic [62:0]  mag;
  logic [63:0]  res_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MS_IDLE: if (start) state_nxt = MS_MUL;
      MS_MUL:  if (cnt_r == 3'd4) state_nxt = MS_SHF;
      MS_SHF:  state_nxt = MS_SAT;
      MS_SAT:  state_nxt = MS_IDLE;
      default: state_nxt = MS_IDLE;
    endcase
  end

  always_comb begin
    ld  = (state_r == MS_IDLE) && start;
    run = (state_r == MS_MUL);
    shf = (state_r == MS_SHF);
    fin = (state_r == MS_SAT);
  end

  assign ha      = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign hb      = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp_full = {32'b0, ha} * {32'b0, hb};

  // floor of a negative quotient: round magnitude up before the shift
  assign bias = (mode_r == MODE_FLOOR && neg_r) ? ((128'd1 << sh_r) - 128'd1) : 128'd0;

  always_comb begin
    mag = (q_r[127:63] != '0 || q_r[62:0] > lim_r) ? lim_r : q_r[62:0];
    if (mode_r == MODE_RAW) begin
      res_nxt = neg_r ? (~q_r[63:0] + 64'd1) : q_r[63:0];
    end else begin
      res_nxt = neg_r ? (~{1'b0, mag} + 64'd1) : {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
      pp_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= fin;
      if (ld) begin
        cnt_r  <= '0;
        pp_v_r <= 1'b0;
      end else if (run) begin
        cnt_r  <= cnt_r + 3'd1;
        pp_v_r <= (cnt_r != 3'd4);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ma_r   <= a[63] ? (~a + 64'd1) : a;
      mb_r   <= b[63] ? (~b + 64'd1) : b;
      neg_r  <= a[63] ^ b[63];
      mode_r <= mode;
      sh_r   <= sh;
      lim_r  <= lim;
      acc_r  <= '0;
    end
    if (run) begin
      pp_r  <= pp_full;
      ppw_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      if (pp_v_r) acc_r <= acc_r + ({64'b0, pp_r} << {ppw_r, 5'b0});
    end
    if (shf) q_r <= (acc_r + bias) >> sh_r;
    if (fin) res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ----- hdl/ddoc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoc_ctrl
// Sequencer: primes on the first request; after that walks the operation table,
// starts the CORDIC and commits each result. Every result is emitted.
// ----------------------------------------------------------------------------
module ddoc_ctrl
  import ddoc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = sts.primed ? ST_INIT : ST_PRIME;
      ST_PRIME:    state_nxt = ST_EMIT;
      ST_INIT: begin
        state_nxt = ST_MUL_GO;
        pc_nxt    = '0;
      end
      ST_MUL_GO:   state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts.mul_done) begin
          priority if (pc_r == OP_PRE_CORDIC) begin
            state_nxt = ST_CORD_GO;
          end else if (pc_r == OP_LAST) begin
            state_nxt = ST_COMMIT;
          end else begin
            state_nxt = ST_MUL_GO;
            pc_nxt    = pc_r + PC_W'(1);
          end
        end
      end
      ST_CORD_GO:  state_nxt = ST_CORD_RUN;
      ST_CORD_RUN: begin
        if (sts.cord_done) begin
          state_nxt = ST_MUL_GO;
          pc_nxt    = pc_r + PC_W'(1);
        end
      end
      ST_COMMIT:   state_nxt = ST_EMIT;
      ST_EMIT:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    cmd.load_in    = (state_r == ST_IDLE) && in_valid;
    cmd.prime      = (state_r == ST_PRIME);
    cmd.init_acc   = (state_r == ST_INIT);
    cmd.mul_start  = (state_r == ST_MUL_GO);
    cmd.cord_start = (state_r == ST_CORD_GO);
    cmd.commit     = (state_r == ST_COMMIT);
    cmd.emit       = (state_r == ST_EMIT) && sts.out_free;
    cmd.pc         = pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// ----- hdl/ddoc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddoc_datapath
// Configuration, pose and covariance state, operand selection around the
// shared multiplier, iterative CORDIC and the output register.
// ----------------------------------------------------------------------------
module ddoc_datapath
  import ddoc_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  in_item_t             in_data,
  input  ctrl_cmd_t            cmd,
  output ctrl_sts_t            sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int CW = $clog2(CORDIC_STEPS + 1);

  // configuration
  logic [31:0] start_x_r, start_y_r, start_head_r, mpp_r, iwb_r, var_r;

  // pose / covariance state
  in_item_t           in_r;
  logic [31:0]        prev_right_r, prev_left_r;
  logic               primed_r;
  logic signed [31:0] cur_x_r, cur_y_r;
  logic [31:0]        cur_head_r;
  logic signed [47:0] cov_xx_r, cov_xy_r, cov_xa_r, cov_yy_r, cov_ya_r, cov_aa_r;

  // intermediate products
  logic signed [63:0] tr_r, tl_r, radq_r, prod_r, dx_r, dy_r, a_r, b_r, hs_r, hc_r;
  logic signed [63:0] q2t_r, q2_r, cc_r, ss_r, csp_r, hs2_r, hc2_r, hsc_r;
  logic signed [63:0] aa_r, ab_r, bb_r;
  logic signed [51:0] acc0_r, acc1_r, acc2_r, acc3_r, acc4_r;

  // CORDIC
  logic signed [33:0] cx_r, cy_r, cz_r, c_r, s_r;
  logic [1:0]         cq_r;
  logic [CW-1:0]      ccnt_r;
  logic               cbusy_r, cdone_r;

  logic      out_valid_r;
  out_item_t out_r;

  logic [31:0]        dr, dl, theta, tq;
  logic signed [63:0] dd, w, opa, opb, mres, scaled;
  logic [62:0]        lim_val;
  op_t                op;
  logic               mul_done;
  logic [63:0]        mul_res;
  logic signed [33:0] sx, sy, at;
  logic signed [41:0] x_sum, y_sum;
  logic signed [31:0] x_new, y_new;
  logic [46:0]        q2_sat;
  logic signed [51:0] aa_sum;

  function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
    logic signed [47:0] r;
    if (v[51:47] == 5'b00000 || v[51:47] == 5'b11111) begin
      r = v[47:0];
    end else begin
      r = v[51] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v[41:31] == '0 || v[41:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[41] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  assign dr = in_r.count_right - prev_right_r;
  assign dl = prev_left_r - in_r.count_left;
  assign dd = (tr_r + tl_r) >>> 1;
  assign w  = tr_r - tl_r;
  assign op = op_info(cmd.pc);

  function automatic logic signed [63:0] pick(
    input src_t sel, input logic [31:0] vdr, input logic [31:0] vdl,
    input logic signed [63:0] vw, input logic signed [63:0] vdd);
    logic signed [63:0] r;
    unique case (sel)
      SRC_DR:   r = {{32{vdr[31]}}, vdr};
      SRC_DL:   r = {{32{vdl[31]}}, vdl};
      SRC_MPP:  r = {32'b0, mpp_r};
      SRC_W:    r = vw;
      SRC_IWB:  r = {32'b0, iwb_r};
      SRC_RADQ: r = radq_r;
      SRC_KBAM: r = BAM_PER_RAD_Q4;
      SRC_DD:   r = vdd;
      SRC_C:    r = {{30{c_r[33]}}, c_r};
      SRC_S:    r = {{30{s_r[33]}}, s_r};
      SRC_A:    r = a_r;
      SRC_B:    r = b_r;
      SRC_HS:   r = hs_r;
      SRC_HC:   r = hc_r;
      SRC_VAR:  r = {32'b0, var_r};
      SRC_Q2T:  r = q2t_r;
      SRC_Q1:   r = {41'b0, var_r[31:9]};
      SRC_Q2:   r = q2_r;
      SRC_CC:   r = cc_r;
      SRC_SS:   r = ss_r;
      SRC_CSP:  r = csp_r;
      SRC_HS2:  r = hs2_r;
      SRC_HC2:  r = hc2_r;
      SRC_HSC:  r = hsc_r;
      SRC_AA:   r = aa_r;
      SRC_AB:   r = ab_r;
      SRC_BB:   r = bb_r;
      SRC_PXA:  r = {{16{cov_xa_r[47]}}, cov_xa_r};
      SRC_PYA:  r = {{16{cov_ya_r[47]}}, cov_ya_r};
      SRC_PAA:  r = {{16{cov_aa_r[47]}}, cov_aa_r};
      default:  r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    opa = pick(op.src_a, dr, dl, w, dd);
    opb = pick(op.src_b, dr, dl, w, dd);
    unique case (op.lim)
      LIM_BIG: lim_val = LIM_BIG_VAL;
      LIM_COV: lim_val = LIM_COV_VAL;
      LIM_POS: lim_val = LIM_POS_VAL;
      default: lim_val = LIM_BIG_VAL;
    endcase
  end

  ddoc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (opa),
    .b     (opb),
    .mode  (op.mode),
    .sh    (op.sh),
    .lim   (lim_val),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    mres = mul_res;
    unique case (op.scale)
      SCL_ONE: scaled = mres;
      SCL_TWO: scaled = mres <<< 1;
      SCL_NEG: scaled = -mres;
      default: scaled = mres;
    endcase
  end

  // CORDIC setup: fold the midpoint heading into the [-1/8, 1/8) turn sector
  assign theta = cur_head_r + prod_r[60:29];
  assign tq    = theta + 32'h2000_0000;
  assign sx    = cx_r >>> ccnt_r;
  assign sy    = cy_r >>> ccnt_r;
  assign at    = $signed({4'b0, atan_bam(5'(ccnt_r))});

  assign x_sum  = {{10{cur_x_r[31]}}, cur_x_r} + dx_r[41:0];
  assign y_sum  = {{10{cur_y_r[31]}}, cur_y_r} + dy_r[41:0];
  assign x_new  = sat32(x_sum);
  assign y_new  = sat32(y_sum);
  assign q2_sat = (q2_r > 64'sh7FFF_FFFF_FFFF) ? {47{1'b1}} : q2_r[46:0];
  assign aa_sum = {{4{cov_aa_r[47]}}, cov_aa_r} + {5'b0, q2_sat};

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_head_r <= '0;
      mpp_r        <= RST_MM_PER_PULSE;
      iwb_r        <= RST_INV_WHEEL_BASE;
      var_r        <= RST_ENCODER_VARIANCE;
      prev_right_r <= '0;
      prev_left_r  <= '0;
      primed_r     <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      cur_head_r   <= '0;
      cov_xx_r     <= '0;
      cov_xy_r     <= '0;
      cov_xa_r     <= '0;
      cov_yy_r     <= '0;
      cov_ya_r     <= '0;
      cov_aa_r     <= '0;
      cbusy_r      <= 1'b0;
      cdone_r      <= 1'b0;
      ccnt_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_X:          start_x_r    <= cfg_wdata;
          CFG_START_Y:          start_y_r    <= cfg_wdata;
          CFG_START_HEADING:    start_head_r <= cfg_wdata;
          CFG_MM_PER_PULSE:     mpp_r        <= cfg_wdata;
          CFG_INV_WHEEL_BASE:   iwb_r        <= cfg_wdata;
          CFG_ENCODER_VARIANCE: var_r        <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.prime) begin
        cur_x_r      <= start_x_r;
        cur_y_r      <= start_y_r;
        cur_head_r   <= start_head_r;
        primed_r     <= 1'b1;
        prev_right_r <= in_r.count_right;
        prev_left_r  <= in_r.count_left;
      end
      if (cmd.commit) begin
        cur_x_r      <= x_new;
        cur_y_r      <= y_new;
        cur_head_r   <= cur_head_r + prod_r[59:28];
        cov_xx_r     <= sat48(acc0_r);
        cov_xy_r     <= sat48(acc1_r);
        cov_xa_r     <= sat48(acc2_r);
        cov_yy_r     <= sat48(acc3_r);
        cov_ya_r     <= sat48(acc4_r);
        cov_aa_r     <= sat48(aa_sum);
        prev_right_r <= in_r.count_right;
        prev_left_r  <= in_r.count_left;
      end
      cdone_r <= 1'b0;
      if (cmd.cord_start) begin
        cbusy_r <= 1'b1;
        ccnt_r  <= '0;
      end else if (cbusy_r) begin
        if (ccnt_r == CW'(CORDIC_STEPS)) begin
          cbusy_r <= 1'b0;
          cdone_r <= 1'b1;
        end else begin
          ccnt_r <= ccnt_r + CW'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.init_acc) begin
      acc0_r <= {{4{cov_xx_r[47]}}, cov_xx_r};
      acc1_r <= {{4{cov_xy_r[47]}}, cov_xy_r};
      acc2_r <= {{4{cov_xa_r[47]}}, cov_xa_r};
      acc3_r <= {{4{cov_yy_r[47]}}, cov_yy_r};
      acc4_r <= {{4{cov_ya_r[47]}}, cov_ya_r};
    end
    if (mul_done) begin
      unique case (op.dest)
        DST_TR:   tr_r   <= scaled;
        DST_TL:   tl_r   <= scaled;
        DST_RADQ: radq_r <= scaled;
        DST_PROD: prod_r <= scaled;
        DST_DX:   dx_r   <= scaled;
        DST_DY:   dy_r   <= scaled;
        DST_A:    a_r    <= scaled;
        DST_B:    b_r    <= scaled;
        DST_HS:   hs_r   <= scaled;
        DST_HC:   hc_r   <= scaled;
        DST_Q2T:  q2t_r  <= scaled;
        DST_Q2:   q2_r   <= scaled;
        DST_CC:   cc_r   <= scaled;
        DST_SS:   ss_r   <= scaled;
        DST_CSP:  csp_r  <= scaled;
        DST_HS2:  hs2_r  <= scaled;
        DST_HC2:  hc2_r  <= scaled;
        DST_HSC:  hsc_r  <= scaled;
        DST_AA:   aa_r   <= scaled;
        DST_AB:   ab_r   <= scaled;
        DST_BB:   bb_r   <= scaled;
        DST_ACC0: acc0_r <= acc0_r + scaled[51:0];
        DST_ACC1: acc1_r <= acc1_r + scaled[51:0];
        DST_ACC2: acc2_r <= acc2_r + scaled[51:0];
        DST_ACC3: acc3_r <= acc3_r + scaled[51:0];
        DST_ACC4: acc4_r <= acc4_r + scaled[51:0];
        default: ;
      endcase
    end
    if (cmd.cord_start) begin
      cq_r <= tq[31:30];
      cz_r <= $signed({4'b0, tq[29:0]}) - 34'sd536870912;
      cx_r <= CORDIC_GAIN;
      cy_r <= '0;
    end else if (cbusy_r) begin
      if (ccnt_r == CW'(CORDIC_STEPS)) begin
        // quadrant rotation back from the folded sector
        unique case (cq_r)
          2'd0: begin c_r <= cx_r;  s_r <= cy_r;  end
          2'd1: begin c_r <= -cy_r; s_r <= cx_r;  end
          2'd2: begin c_r <= -cx_r; s_r <= -cy_r; end
          default: begin c_r <= cy_r; s_r <= -cx_r; end
        endcase
      end else if (!cz_r[33]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - at;
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + at;
      end
    end
    if (cmd.emit) begin
      out_r.pose_x       <= cur_x_r;
      out_r.pose_y       <= cur_y_r;
      out_r.pose_heading <= cur_head_r;
      out_r.var_xx       <= cov_xx_r;
      out_r.var_xy       <= cov_xy_r;
      out_r.var_xa       <= cov_xa_r;
      out_r.var_yy       <= cov_yy_r;
      out_r.var_ya       <= cov_ya_r;
      out_r.var_aa       <= cov_aa_r;
    end
  end

  always_comb begin
    sts.primed    = primed_r;
    sts.mul_done  = mul_done;
    sts.cord_done = cdone_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hdl/diff_drive_odometry_covariance.sv -----
`timescale 1ns / 1ps
// Sequence: the first request after reset (priming) passes through the prime
//   and emit states only; each later request runs 38 products in turn on the
//   one shared multiplier, with the CORDIC (one iteration per cycle) between
//   the heading product and the pose deltas. One request in flight; the next
//   is taken the cycle after the result is handed to the output register.
// Reset: synchronous, active low; clears pose, covariance and previous counts, sets config registers to defaults.
// ----------------------------------------------------------------------------
// diff_drive_odometry_covariance
// Differential-drive odometry with 3x3 pose covariance propagation.
// ----------------------------------------------------------------------------
module diff_drive_odometry_covariance
  import ddoc_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ddoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddoc_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/diff_drive_odometry_covariance_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_odometry_covariance_test
// Drives encoder count pairs and register settings into the odometry block,
// tracks pose and covariance with an independent fixed-point model and checks
// every result field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module diff_drive_odometry_covariance_test;
  import ddoc_pkg::*;

  localparam int           STEPS   = 24;
  localparam longint       LIM_BIG = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint       LIM_COV = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint       LIM_POS = 64'sh0000_0100_0000_0000;
  localparam int           ITEMS_PER_PHASE = 80;
  localparam int           NUM_PHASES = 8;

  // Pose and covariance tracker with a queue of pending results.
  class pose_tracker;
    logic [31:0] regs [6];
    longint      x, y;
    logic [31:0] heading, last_r, last_l;
    bit          primed;
    longint      cov [6];
    out_item_t   pending_poses [$];
    string       faults [$];
    longint      atan_tab [STEPS];

    function void init();
      longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                         21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
                         1304, 652, 326, 163, 81};
      for (int i = 0; i < STEPS; i++) atan_tab[i] = t[i];
      regs[CFG_START_X] = '0;
      regs[CFG_START_Y] = '0;
      regs[CFG_START_HEADING] = '0;
      regs[CFG_MM_PER_PULSE] = RST_MM_PER_PULSE;
      regs[CFG_INV_WHEEL_BASE] = RST_INV_WHEEL_BASE;
      regs[CFG_ENCODER_VARIANCE] = RST_ENCODER_VARIANCE;
      x = 0; y = 0; heading = 0; last_r = 0; last_l = 0; primed = 0;
      foreach (cov[i]) cov[i] = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
      regs[idx] = v;
    endfunction

    function int pending();
      return pending_poses.size();
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // (a*b) >> sh toward zero, magnitude clipped to lim
    static function longint scaled_product(longint a, longint b, int sh, longint lim);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> sh;
      if (p > lim) p = lim;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void sin_cos(logic [31:0] theta, output longint c, output longint s);
      logic [31:0] t;
      longint      z, cx, cy, nx;
      t = theta + 32'h2000_0000;
      z = longint'({34'd0, t[29:0]}) - 64'sd536870912;
      cx = CORDIC_GAIN;
      cy = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= atan_tab[i];
        end else begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += atan_tab[i];
        end
        cx = nx;
      end
      case (t[31:30])
        2'd0: begin c = cx; s = cy; end
        2'd1: begin c = -cy; s = cx; end
        2'd2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
    endfunction

    function void advance(logic [31:0] cr, logic [31:0] cl);
      logic [31:0] diff_r, diff_l, half, dang;
      logic [63:0] prod, q2u;
      longint dr, dl, mpp, iwb, tr, tl, dd, w, radq, c, s, a, b, hs, hc;
      longint q1, q2, cc, ss, csp, hs2, hc2, hsc;
      longint pxx, pxy, pxa, pyy, pya, paa;
      diff_r = cr - last_r;
      diff_l = last_l - cl;
      dr = longint'($signed(diff_r));
      dl = longint'($signed(diff_l));
      mpp = longint'({32'd0, regs[CFG_MM_PER_PULSE]});
      iwb = longint'({32'd0, regs[CFG_INV_WHEEL_BASE]});
      tr = (dr * mpp) >>> 8;
      tl = (dl * mpp) >>> 8;
      dd = (tr + tl) >>> 1;
      w = tr - tl;
      radq = scaled_product(w, iwb, 32, LIM_BIG);
      prod = 64'(radq) * BAM_PER_RAD_Q4;
      half = prod[60:29];
      dang = prod[59:28];
      sin_cos(heading + half, c, s);
      x = clip(x + scaled_product(dd, c, 38, LIM_POS), -64'sd2147483648, 64'sd2147483647);
      y = clip(y + scaled_product(dd, s, 38, LIM_POS), -64'sd2147483648, 64'sd2147483647);
      a = -scaled_product(dd, s, 30, LIM_BIG);
      b = scaled_product(dd, c, 30, LIM_BIG);
      hs = scaled_product(dd, s, 31, LIM_BIG);
      hc = scaled_product(dd, c, 31, LIM_BIG);
      q1 = longint'({32'd0, regs[CFG_ENCODER_VARIANCE] >> 9});
      q2u = ((({32'd0, regs[CFG_ENCODER_VARIANCE]} * {32'd0, regs[CFG_INV_WHEEL_BASE]})
             >> 32) * {32'd0, regs[CFG_INV_WHEEL_BASE]}) >> 39;
      q2 = longint'(q2u);
      cc = scaled_product(c, c, 30, LIM_BIG);
      ss = scaled_product(s, s, 30, LIM_BIG);
      csp = scaled_product(c, s, 30, LIM_BIG);
      hs2 = scaled_product(hs, hs, 24, LIM_BIG);
      hc2 = scaled_product(hc, hc, 24, LIM_BIG);
      hsc = scaled_product(hs, hc, 24, LIM_BIG);
      pxx = cov[0]; pxy = cov[1]; pxa = cov[2];
      pyy = cov[3]; pya = cov[4]; paa = cov[5];
      cov[0] = clip(pxx + 2 * scaled_product(a, pxa, 24, LIM_COV)
               + scaled_product(scaled_product(a, a, 24, LIM_BIG), paa, 24, LIM_COV)
               + scaled_product(q1, cc, 30, LIM_COV)
               + scaled_product(q2, hs2, 24, LIM_COV), -LIM_COV - 1, LIM_COV);
      cov[1] = clip(pxy + scaled_product(a, pya, 24, LIM_COV)
               + scaled_product(b, pxa, 24, LIM_COV)
               + scaled_product(scaled_product(a, b, 24, LIM_BIG), paa, 24, LIM_COV)
               + scaled_product(q1, csp, 30, LIM_COV)
               - scaled_product(q2, hsc, 24, LIM_COV), -LIM_COV - 1, LIM_COV);
      cov[2] = clip(pxa + scaled_product(a, paa, 24, LIM_COV)
               - scaled_product(q2, hs, 24, LIM_COV), -LIM_COV - 1, LIM_COV);
      cov[3] = clip(pyy + 2 * scaled_product(b, pya, 24, LIM_COV)
               + scaled_product(scaled_product(b, b, 24, LIM_BIG), paa, 24, LIM_COV)
               + scaled_product(q1, ss, 30, LIM_COV)
               + scaled_product(q2, hc2, 24, LIM_COV), -LIM_COV - 1, LIM_COV);
      cov[4] = clip(pya + scaled_product(b, paa, 24, LIM_COV)
               + scaled_product(q2, hc, 24, LIM_COV), -LIM_COV - 1, LIM_COV);
      cov[5] = clip(paa + clip(q2, 0, LIM_COV), -LIM_COV - 1, LIM_COV);
      heading += dang;
    endfunction

    function void note_request(in_item_t req);
      out_item_t e;
      if (!primed) begin
        x = longint'($signed(regs[CFG_START_X]));
        y = longint'($signed(regs[CFG_START_Y]));
        heading = regs[CFG_START_HEADING];
        primed = 1;
      end else begin
        advance(req.count_right, req.count_left);
      end
      last_r = req.count_right;
      last_l = req.count_left;
      e.pose_x = x[31:0];
      e.pose_y = y[31:0];
      e.pose_heading = heading;
      e.var_xx = cov[0][47:0];
      e.var_xy = cov[1][47:0];
      e.var_xa = cov[2][47:0];
      e.var_yy = cov[3][47:0];
      e.var_ya = cov[4][47:0];
      e.var_aa = cov[5][47:0];
      pending_poses.push_back(e);
    endfunction

    function void cmp(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want)
        faults.push_back($sformatf("%s got %h expected %h", name, got, want));
    endfunction

    function void check_pose(out_item_t got);
      out_item_t e;
      if (pending_poses.size() == 0) begin
        faults.push_back("result with no request outstanding");
        return;
      end
      e = pending_poses.pop_front();
      cmp("pose_x", 48'(got.pose_x), 48'(e.pose_x));
      cmp("pose_y", 48'(got.pose_y), 48'(e.pose_y));
      cmp("pose_heading", 48'(got.pose_heading), 48'(e.pose_heading));
      cmp("var_xx", got.var_xx, e.var_xx);
      cmp("var_xy", got.var_xy, e.var_xy);
      cmp("var_xa", got.var_xa, e.var_xa);
      cmp("var_yy", got.var_yy, e.var_yy);
      cmp("var_ya", got.var_ya, e.var_ya);
      cmp("var_aa", got.var_aa, e.var_aa);
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 0;
  out_item_t            out_data;
  logic                 cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  pose_tracker board = new();
  int          mismatches = 0;
  int          requests_sent = 0;
  int          poses_seen = 0;
  int          burst_left = 0;
  logic [31:0] enc_r = 0, enc_l = 0;

  diff_drive_odometry_covariance dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #10 clk = ~clk;

  initial begin
    #100ms;
    $display("Timeout waiting for the block");
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // receiver stall pattern: a random mode, redrawn when its random countdown expires
  int stall_mode = 0, stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_count <= $urandom_range(50, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 80);
      default: out_stall <= stall_count[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      poses_seen++;
      board.check_pose(out_data);
      while (board.faults.size() != 0) report_mismatch(board.faults.pop_front());
    end
  end

  task automatic program_regs(logic [31:0] v [6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= v[i];
      board.write_reg(i, v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one request; valid stays up unless a gap follows
  task automatic send_counts(logic [31:0] cr, logic [31:0] cl);
    in_item_t req;
    req.count_right = cr;
    req.count_left = cl;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    board.note_request(req);
    requests_sent++;
    enc_r = cr;
    enc_l = cl;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 450)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_motion(int n);
    int kind, dv, turn;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        dv = $urandom_range(0, 4000) - 2000;
        turn = $urandom_range(0, 600) - 300;
        send_counts(enc_r + 32'(dv + turn), enc_l - 32'(dv - turn));
      end else if (kind < 90) begin
        send_counts(enc_r + $urandom(), enc_l + $urandom());
      end else begin
        send_counts($urandom(), $urandom());
      end
    end
  endtask

  initial begin
    logic [31:0] v [6];
    board.init();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    v = '{32'h7FFF_FFFF, 32'h8000_0000, $urandom(), RST_MM_PER_PULSE,
          RST_INV_WHEEL_BASE, RST_ENCODER_VARIANCE};
    program_regs(v);

    // priming, then zero motion, straight runs, spins, counter wrap, extremes
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    send_counts(32'h7FFF_FFFF, 32'h8000_0000);
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_counts(32'h8000_0100, 32'h7FFF_FEFF);
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_counts(32'h8000_0400, 32'h8000_0400);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'h8000_0000, 32'h8000_0000);
    send_counts(32'h0000_0000, 32'h0000_0000);
    send_counts(32'h7FFF_FFFF, 32'h8000_0001);
    send_counts(32'h8000_0000, 32'h7FFF_FFFF);
    send_counts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_counts(32'h0000_0000, 32'h0000_0000);
    for (int i = 0; i < 8; i++) send_counts(enc_r + 32'd5000, enc_l - 32'd5000);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: v = '{$urandom(), $urandom(), $urandom(), 32'd0, RST_INV_WHEEL_BASE,
                 RST_ENCODER_VARIANCE};
        1: v = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        2: v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, RST_MM_PER_PULSE,
                 32'd0, 32'd0};
        3: v = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        4: v = '{32'h0, 32'h0, 32'h0, 32'd1, 32'd1, 32'd1};
        5: v = '{$urandom(), $urandom(), $urandom(), 32'hFFFF_FFFF, 32'd24826400,
                 32'd0};
        6: v = '{$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        default: v = '{32'h0, 32'h0, 32'h0, RST_MM_PER_PULSE, RST_INV_WHEEL_BASE,
                       RST_ENCODER_VARIANCE};
      endcase
      program_regs(v);
      random_motion(ITEMS_PER_PHASE);
      drain();
    end

    $display("Sent %0d requests over %0d register settings, checked %0d results",
             requests_sent, NUM_PHASES + 1, poses_seen);
    $display("Covered priming, counter wrap, zero and extreme scale registers");
    if (mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      if (board.pending() != 0) report_mismatch("results left outstanding at end");
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ddoc_pkg.sv
hdl/ddoc_mul.sv
hdl/ddoc_ctrl.sv
hdl/ddoc_datapath.sv
hdl/diff_drive_odometry_covariance.sv
tb/sv/diff_drive_odometry_covariance_test.sv
